// ===== design/bsci_pkg.sv =====
`default_nettype none
package bsci_pkg;

  // Field and register widths
  localparam int unsigned SMP_W     = 16;
  localparam int unsigned TIME_W    = 48;
  localparam int unsigned PERIOD_W  = 32;
  localparam int unsigned BF_W      = 9;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 32;

  // Block geometry defaults
  localparam int unsigned MAX_BLOCK_DEF = 256;
  localparam int unsigned CLICK_HALF    = 7;
  localparam int unsigned CLICK_LEN     = 2 * CLICK_HALF + 1;
  localparam int unsigned CLICK_IDX_W   = $clog2(CLICK_LEN);

  // Command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD       = 2'd0,
    CFG_REPLACE_MODE = 2'd1,
    CFG_BLOCK_FRAMES = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_DIV,
    F_CHK,
    F_QDIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_CLICK,
    B_READ,
    B_OUT
  } back_state_t;

  // Symmetric parabola click
  function automatic logic [SMP_W-1:0] click_shape(input logic [CLICK_IDX_W-1:0] idx);
    logic [SMP_W-1:0] v;
    unique case (idx)
      4'd7:          v = 16'd20742;
      4'd6,  4'd8:   v = 16'd19759;
      4'd5,  4'd9:   v = 16'd18121;
      4'd4,  4'd10:  v = 16'd15827;
      4'd3,  4'd11:  v = 16'd12878;
      4'd2,  4'd12:  v = 16'd9273;
      4'd1,  4'd13:  v = 16'd5014;
      4'd0,  4'd14:  v = 16'd98;
      default:       v = 16'd0;
    endcase
    return v;
  endfunction

  // Clamp the block length register to 1 .. max_blk
  function automatic logic [31:0] eff_block(input logic [BF_W-1:0] bf,
                                            input logic [31:0] max_blk);
    logic [31:0] n;
    n = 32'(bf);
    if (n == 32'd0) n = 32'd1;
    if (n > max_blk) n = max_blk;
    return n;
  endfunction

endpackage
`default_nettype wire

// ===== design/beat_synced_click_inserter_unit.sv =====
`default_nettype none
// Beat-synchronous click inserter for one mono audio stream. A plain frame is
// pushed into the command queue by the front end in the cycle it is taken and
// played by the back end in three steps (queue pop, store read-and-clear,
// output register), the last waiting until the output is free. The first frame
// of a block with usable times holds the front end while two 48-step restoring
// dividers run in lockstep on the block start times, a check state tests for a
// single beat, then, only when exactly one beat falls inside the block, one
// multiply and an N-step divide, N = clog2(MAX_BLOCK+1), give the click offset;
// the back end then writes the 15-sample click shape into the future store
// through its single write port. A two-entry command queue sits between the two
// halves. After reset the back end clears all MAX_BLOCK+15 entries of the future
// store (271 at the default), one entry a cycle, and no frame is taken until
// that pass is done. Configuration may be written at any time the block is idle
// and takes effect on the next frame.
module beat_synced_click_inserter_unit #(
  parameter int unsigned MAX_BLOCK = bsci_pkg::MAX_BLOCK_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [bsci_pkg::SMP_W-1:0] in_sample_in,
  input  wire logic                              in_first_of_block,
  input  wire logic                              in_times_valid,
  input  wire logic [bsci_pkg::TIME_W-1:0]       in_block_start_time,
  input  wire logic [bsci_pkg::TIME_W-1:0]       in_next_block_start_time,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [bsci_pkg::SMP_W-1:0]      out_sample_out,
  input  wire logic                              cfg_we,
  input  wire logic [bsci_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire logic [bsci_pkg::CFG_DAT_W-1:0]    cfg_wdata
);

  localparam int unsigned N_W   = $clog2(MAX_BLOCK + 1);
  localparam int unsigned CMD_W = bsci_pkg::SMP_W + 2 + N_W;

  logic [bsci_pkg::PERIOD_W-1:0] beat_len_r;
  logic                          replace_mode_r;
  logic [bsci_pkg::BF_W-1:0]     block_frames_r;

  logic             clearing;
  logic             q_full;
  logic             q_push;
  logic [CMD_W-1:0] q_wdata;
  logic             q_pop;
  logic             q_valid;
  logic [CMD_W-1:0] q_rdata;
  logic [bsci_pkg::SMP_W-1:0] out_sample;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_len_r     <= '0;
      replace_mode_r <= 1'b1;
      block_frames_r <= bsci_pkg::BF_W'(64);
    end else if (cfg_we) begin
      unique case (bsci_pkg::cfg_idx_t'(cfg_idx))
        bsci_pkg::CFG_PERIOD:       beat_len_r     <= cfg_wdata[bsci_pkg::PERIOD_W-1:0];
        bsci_pkg::CFG_REPLACE_MODE: replace_mode_r <= cfg_wdata[0];
        bsci_pkg::CFG_BLOCK_FRAMES: block_frames_r <= cfg_wdata[bsci_pkg::BF_W-1:0];
        default: ;
      endcase
    end
  end

  bsci_front #(.MAX_BLOCK(MAX_BLOCK)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample      (in_sample_in),
    .in_first       (in_first_of_block),
    .in_times_valid (in_times_valid),
    .in_t0          (in_block_start_time),
    .in_t1          (in_next_block_start_time),
    .beat_len       (beat_len_r),
    .block_frames   (block_frames_r),
    .clearing       (clearing),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_wdata)
  );

  bsci_fifo #(.WIDTH(CMD_W)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_rdata)
  );

  bsci_back #(.MAX_BLOCK(MAX_BLOCK)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_data       (q_rdata),
    .q_pop        (q_pop),
    .replace_mode (replace_mode_r),
    .block_frames (block_frames_r),
    .clearing     (clearing),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_sample   (out_sample)
  );

  assign out_sample_out = out_sample;

  // No frame enters while the store is being cleared
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_ready)
    else $error("input taken during store clearing");

  // Front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("command queue overflow");

  // Back never pops an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("command queue underflow");

  // Reset leaves no result pending
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule
`default_nettype wire

// ===== design/bsci_fifo.sv =====
`default_nettype none
module bsci_fifo #(
  parameter int unsigned WIDTH = 20
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  valid,
  output logic [WIDTH-1:0]      pop_data
);

  localparam int unsigned DEPTH = bsci_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] ent_r [DEPTH];
  logic [PTR_W-1:0] wptr_r;
  logic [PTR_W-1:0] rptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign valid    = (cnt_r != '0);
  assign pop_data = ent_r[rptr_r];

  // Hold entries
  always_ff @(posedge clk) begin
    if (push) ent_r[wptr_r] <= push_data;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop)  rptr_r <= rptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== design/bsci_front.sv =====
`default_nettype none
module bsci_front #(
  parameter int unsigned MAX_BLOCK = bsci_pkg::MAX_BLOCK_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [bsci_pkg::SMP_W-1:0]         in_sample,
  input  wire logic                               in_first,
  input  wire logic                               in_times_valid,
  input  wire logic [bsci_pkg::TIME_W-1:0]        in_t0,
  input  wire logic [bsci_pkg::TIME_W-1:0]        in_t1,
  input  wire logic [bsci_pkg::PERIOD_W-1:0]      beat_len,
  input  wire logic [bsci_pkg::BF_W-1:0]          block_frames,
  input  wire logic                               clearing,
  input  wire logic                               q_full,
  output logic                                    q_push,
  output logic [bsci_pkg::SMP_W+2+$clog2(MAX_BLOCK+1)-1:0] q_data
);

  localparam int unsigned N_W    = $clog2(MAX_BLOCK + 1);
  localparam int unsigned TW     = bsci_pkg::TIME_W;
  localparam int unsigned PW     = bsci_pkg::PERIOD_W;
  localparam int unsigned REM_W  = PW + N_W;
  localparam int unsigned SD_W   = TW + N_W;
  localparam int unsigned CNT_W  = $clog2(TW);

  bsci_pkg::front_state_t state_r, state_nxt;

  logic [bsci_pkg::SMP_W-1:0] smp_r;
  logic                       first_r;
  logic [TW-1:0]              span_r;
  logic [TW-1:0]              dq0_r, dq1_r;
  logic [PW-1:0]              rm0_r, rm1_r;
  logic [REM_W-1:0]           rem_r;
  logic [SD_W-1:0]            sd_r;
  logic [N_W-1:0]             off_r;
  logic                       match_r;
  logic [CNT_W-1:0]           cnt_r;

  logic             accept;
  logic             need_math;
  logic [N_W-1:0]   n;
  logic [PW:0]      t0x, t1x, sub0, sub1;
  logic             ge0, ge1;
  logic [PW-1:0]    rm0_step, rm1_step;
  logic [TW:0]      beat;
  logic             match;
  logic [PW-1:0]    gap;
  logic [REM_W-1:0] prod;
  logic [SD_W-1:0]  remx;
  logic             qge;
  logic [REM_W-1:0] rem_step;
  logic             div_done, qdiv_done;

  assign n         = N_W'(bsci_pkg::eff_block(block_frames, 32'(MAX_BLOCK)));
  assign in_ready  = (state_r == bsci_pkg::F_IDLE) && !q_full && !clearing;
  assign accept    = in_valid && in_ready;
  assign need_math = in_first && in_times_valid && (beat_len != '0) && (in_t0 < in_t1);

  // One restoring step on each time
  assign t0x      = {rm0_r, dq0_r[TW-1]};
  assign t1x      = {rm1_r, dq1_r[TW-1]};
  assign sub0     = t0x - {1'b0, beat_len};
  assign sub1     = t1x - {1'b0, beat_len};
  assign ge0      = (t0x >= {1'b0, beat_len});
  assign ge1      = (t1x >= {1'b0, beat_len});
  assign rm0_step = ge0 ? sub0[PW-1:0] : t0x[PW-1:0];
  assign rm1_step = ge1 ? sub1[PW-1:0] : t1x[PW-1:0];
  assign div_done = (cnt_r == CNT_W'(TW - 1));

  // Beat check: ceil of start quotient against floor of next quotient
  assign beat  = {1'b0, dq0_r} + (TW+1)'(rm0_r != '0);
  assign match = (beat == {1'b0, dq1_r});
  assign gap   = (rm0_r == '0) ? '0 : (beat_len - rm0_r);
  assign prod  = REM_W'(gap) * REM_W'(n);

  // One quotient bit of the offset per cycle
  assign remx      = SD_W'(rem_r);
  assign qge       = (remx >= sd_r);
  assign rem_step  = qge ? REM_W'(remx - sd_r) : rem_r;
  assign qdiv_done = (cnt_r == CNT_W'(N_W - 1));

  // Next state and queue push
  always_comb begin
    state_nxt = state_r;
    q_push    = 1'b0;
    q_data    = {smp_r, first_r, match_r, off_r};
    unique case (state_r)
      bsci_pkg::F_IDLE: begin
        q_data = {in_sample, in_first, 1'b0, N_W'(0)};
        if (accept) begin
          if (need_math) state_nxt = bsci_pkg::F_DIV;
          else           q_push    = 1'b1;
        end
      end
      bsci_pkg::F_DIV: begin
        if (div_done) state_nxt = bsci_pkg::F_CHK;
      end
      bsci_pkg::F_CHK: begin
        state_nxt = match ? bsci_pkg::F_QDIV : bsci_pkg::F_PUSH;
      end
      bsci_pkg::F_QDIV: begin
        if (qdiv_done) state_nxt = bsci_pkg::F_PUSH;
      end
      bsci_pkg::F_PUSH: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = bsci_pkg::F_IDLE;
        end
      end
      default: state_nxt = bsci_pkg::F_IDLE;
    endcase
  end

  // State register and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bsci_pkg::F_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == bsci_pkg::F_DIV && div_done) ||
          (state_r == bsci_pkg::F_QDIV && qdiv_done) || accept) begin
        cnt_r <= '0;
      end else if (state_r == bsci_pkg::F_DIV || state_r == bsci_pkg::F_QDIV) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      smp_r   <= in_sample;
      first_r <= in_first;
      span_r  <= in_t1 - in_t0;
      dq0_r   <= in_t0;
      dq1_r   <= in_t1;
      rm0_r   <= '0;
      rm1_r   <= '0;
      match_r <= 1'b0;
      off_r   <= '0;
    end else begin
      unique case (state_r)
        bsci_pkg::F_DIV: begin
          dq0_r <= {dq0_r[TW-2:0], ge0};
          dq1_r <= {dq1_r[TW-2:0], ge1};
          rm0_r <= rm0_step;
          rm1_r <= rm1_step;
        end
        bsci_pkg::F_CHK: begin
          match_r <= match;
          rem_r   <= prod;
          sd_r    <= SD_W'(span_r) << (N_W - 1);
          off_r   <= '0;
        end
        bsci_pkg::F_QDIV: begin
          rem_r <= rem_step;
          sd_r  <= sd_r >> 1;
          off_r <= N_W'({off_r, qge});
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/bsci_back.sv =====
`default_nettype none
module bsci_back #(
  parameter int unsigned MAX_BLOCK = bsci_pkg::MAX_BLOCK_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_valid,
  input  wire logic [bsci_pkg::SMP_W+2+$clog2(MAX_BLOCK+1)-1:0] q_data,
  output logic                               q_pop,
  input  wire logic                          replace_mode,
  input  wire logic [bsci_pkg::BF_W-1:0]     block_frames,
  output logic                               clearing,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [bsci_pkg::SMP_W-1:0]         out_sample
);

  localparam int unsigned N_W   = $clog2(MAX_BLOCK + 1);
  localparam int unsigned SW    = bsci_pkg::SMP_W;
  localparam int unsigned CL    = bsci_pkg::CLICK_LEN;
  localparam int unsigned IW    = bsci_pkg::CLICK_IDX_W;
  localparam int unsigned DEPTH = MAX_BLOCK + CL;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  bsci_pkg::back_state_t state_r, state_nxt;

  logic [SW-1:0]    mem [DEPTH];
  logic [SW-1:0]    rd_r;
  logic [PTR_W-1:0] clr_r;
  logic [PTR_W-1:0] pp_r;
  logic [PTR_W-1:0] base_r;
  logic [IW-1:0]    idx_r;
  logic [SW-1:0]    smp_r;
  logic [N_W-1:0]   off_r;
  logic             out_valid_r;
  logic [SW-1:0]    out_sample_r;

  logic [SW-1:0]    cmd_smp;
  logic             cmd_first;
  logic             cmd_ins;
  logic [N_W-1:0]   cmd_off;
  logic [N_W-1:0]   n;
  logic [PTR_W:0]   pos, lim, asum;
  logic             in_win;
  logic [PTR_W-1:0] click_addr;
  logic [PTR_W-1:0] pp_inc;
  logic             out_free;
  logic             out_load;
  logic [SW:0]      mix;
  logic [SW-1:0]    mix_sat;
  logic [SW-1:0]    result;
  logic             mem_we;
  logic             mem_re;
  logic [PTR_W-1:0] mem_waddr;
  logic [SW-1:0]    mem_wdata;

  assign cmd_smp   = q_data[SW+N_W+1:N_W+2];
  assign cmd_first = q_data[N_W+1];
  assign cmd_ins   = q_data[N_W];
  assign cmd_off   = q_data[N_W-1:0];

  assign n = N_W'(bsci_pkg::eff_block(block_frames, 32'(MAX_BLOCK)));

  // Click sample address, wrapped round the store
  assign pos        = (PTR_W+1)'(off_r) + (PTR_W+1)'(idx_r);
  assign lim        = (PTR_W+1)'(CL) + (PTR_W+1)'(n);
  assign in_win     = (pos < lim);
  assign asum       = (PTR_W+1)'(base_r) + pos;
  assign click_addr = (asum >= (PTR_W+1)'(DEPTH)) ? PTR_W'(asum - (PTR_W+1)'(DEPTH))
                                                  : PTR_W'(asum);
  assign pp_inc     = (pp_r == PTR_W'(DEPTH - 1)) ? '0 : (pp_r + 1'b1);

  // Replace or mix with saturation
  assign mix     = {smp_r[SW-1], smp_r} + {rd_r[SW-1], rd_r};
  assign mix_sat = (mix[SW] != mix[SW-1]) ? {mix[SW], {(SW-1){~mix[SW]}}} : mix[SW-1:0];
  assign result  = replace_mode ? rd_r : mix_sat;

  assign out_free   = !out_valid_r || out_ready;
  assign clearing   = (state_r == bsci_pkg::B_CLEAR);
  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  // Next state, memory port and queue pop
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    out_load  = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = pp_r;
    mem_wdata = '0;
    unique case (state_r)
      bsci_pkg::B_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        if (clr_r == PTR_W'(DEPTH - 1)) state_nxt = bsci_pkg::B_IDLE;
      end
      bsci_pkg::B_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = cmd_ins ? bsci_pkg::B_CLICK : bsci_pkg::B_READ;
        end
      end
      bsci_pkg::B_CLICK: begin
        mem_we    = in_win;
        mem_waddr = click_addr;
        mem_wdata = bsci_pkg::click_shape(idx_r);
        if (idx_r == IW'(CL - 1)) state_nxt = bsci_pkg::B_READ;
      end
      bsci_pkg::B_READ: begin
        mem_re    = 1'b1;
        mem_we    = 1'b1;
        state_nxt = bsci_pkg::B_OUT;
      end
      bsci_pkg::B_OUT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = bsci_pkg::B_IDLE;
        end
      end
      default: state_nxt = bsci_pkg::B_IDLE;
    endcase
  end

  // Future store: read the played entry and clear it in the same cycle
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_r <= mem[pp_r];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bsci_pkg::B_CLEAR;
      clr_r       <= '0;
      pp_r        <= '0;
      base_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == bsci_pkg::B_CLEAR) clr_r <= clr_r + 1'b1;
      if (q_pop) begin
        idx_r <= '0;
        if (cmd_first) base_r <= pp_r;
      end else if (state_r == bsci_pkg::B_CLICK) begin
        idx_r <= idx_r + 1'b1;
      end
      if (state_r == bsci_pkg::B_READ) pp_r <= pp_inc;
      if (out_load)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      smp_r <= cmd_smp;
      off_r <= cmd_off;
    end
    if (out_load) out_sample_r <= result;
  end

endmodule
`default_nettype wire
